>>> sv/hsv2rgb_pkg.sv
// shared types, constants and sector codes for the hsv to rgb converter
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  // field and datapath widths
  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;
  localparam int CH_W    = 8;
  localparam int VS_W    = 14;   // val*sat, up to 10000
  localparam int FRAC_W  = 6;    // position inside a sector, 0..60
  localparam int NUM_W   = 20;   // channel numerator over 600000
  localparam int SCL_W   = 28;   // 255*n + half
  localparam int DEN_SHIFT = 6;  // 600000 = 64 * 9375
  localparam int TQ_W    = SCL_W - DEN_SHIFT;
  localparam int RECIP_W = 23;
  localparam int PROD_W  = TQ_W + RECIP_W + 1;
  localparam int RECIP_SHIFT = 36;

  typedef logic [HUE_W-1:0]   hue_t;
  typedef logic [PCT_W-1:0]   pct_t;
  typedef logic [CH_W-1:0]    chan_t;
  typedef logic [VS_W-1:0]    vs_t;
  typedef logic [FRAC_W-1:0]  frac_t;
  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [SCL_W-1:0]   scl_t;
  typedef logic [TQ_W-1:0]    tq_t;
  typedef logic [RECIP_W-1:0] recip_t;
  typedef logic [PROD_W-1:0]  prod_t;

  // input limits
  localparam hue_t HUE_MAX = hue_t'(359);
  localparam pct_t PCT_MAX = pct_t'(100);

  // hue sector boundaries, 60 degrees each
  localparam int   SECTOR_SPAN = 60;
  localparam frac_t FRAC_FULL  = frac_t'(SECTOR_SPAN);

  // numerator scale factors over the common denominator 600000
  localparam num_t CM_SCALE  = num_t'(6000);   // 100 * 60
  localparam vs_t  PCT_FULL  = vs_t'(100);
  localparam num_t OFF_SCALE = num_t'(SECTOR_SPAN);
  localparam scl_t HALF_NUM  = scl_t'(300000);

  // ceil(2^36 / 9375), exact floor division for dividends of 22 bits
  localparam recip_t RECIP = recip_t'(7330078);

  // hue sectors, each named by the colors at its start and end
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // per-channel numerators handed from the front end to the scaler
  typedef struct packed {
    num_t red;
    num_t green;
    num_t blue;
  } chan_num_t;

endpackage

`default_nettype wire

>>> sv/hsv2rgb_front.sv
// front end: input clamp, sector split, chroma terms and channel selection (3 stages)
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire hsv2rgb_pkg::hue_t  hue,
  input  wire hsv2rgb_pkg::pct_t  sat,
  input  wire hsv2rgb_pkg::pct_t  val,
  output logic                    num_valid,
  input  wire                     num_ready,
  output hsv2rgb_pkg::chan_num_t  num
);

  // stage 1: clamp, sector, fraction, val*sat
  hsv2rgb_pkg::hue_t    hue_c;
  hsv2rgb_pkg::pct_t    sat_c;
  hsv2rgb_pkg::pct_t    val_c;
  hsv2rgb_pkg::hue_t    base;
  hsv2rgb_pkg::hue_t    diff;
  hsv2rgb_pkg::frac_t   frac;
  hsv2rgb_pkg::sector_t s1_sec_nxt;
  hsv2rgb_pkg::frac_t   s1_f_nxt;
  hsv2rgb_pkg::vs_t     s1_vs_nxt;

  logic                 s1_vld_r;
  hsv2rgb_pkg::sector_t s1_sec_r;
  hsv2rgb_pkg::frac_t   s1_f_r;
  hsv2rgb_pkg::pct_t    s1_val_r;
  hsv2rgb_pkg::vs_t     s1_vs_r;

  // stage 2: numerator terms
  hsv2rgb_pkg::vs_t     offs;
  hsv2rgb_pkg::num_t    s2_cm_nxt;
  hsv2rgb_pkg::num_t    s2_m_nxt;
  hsv2rgb_pkg::num_t    s2_xs_nxt;

  logic                 s2_vld_r;
  hsv2rgb_pkg::sector_t s2_sec_r;
  hsv2rgb_pkg::num_t    s2_cm_r;
  hsv2rgb_pkg::num_t    s2_m_r;
  hsv2rgb_pkg::num_t    s2_xs_r;

  // stage 3: channel placement
  hsv2rgb_pkg::num_t      xm;
  hsv2rgb_pkg::chan_num_t s3_num_nxt;
  logic                   s3_vld_r;
  hsv2rgb_pkg::chan_num_t s3_num_r;

  logic rdy1, rdy2, rdy3;

  assign rdy3     = !s3_vld_r || num_ready;
  assign rdy2     = !s2_vld_r || rdy3;
  assign rdy1     = !s1_vld_r || rdy2;
  assign in_ready = rdy1;

  // ---------------- stage 1 ----------------
  always_comb begin
    hue_c = (hue > hsv2rgb_pkg::HUE_MAX) ? hsv2rgb_pkg::HUE_MAX : hue;
    sat_c = (sat > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : sat;
    val_c = (val > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : val;

    if (hue_c < hsv2rgb_pkg::hue_t'(hsv2rgb_pkg::SECTOR_SPAN)) begin
      s1_sec_nxt = hsv2rgb_pkg::SEC_RED_YEL;
      base       = '0;
    end else if (hue_c < hsv2rgb_pkg::hue_t'(2 * hsv2rgb_pkg::SECTOR_SPAN)) begin
      s1_sec_nxt = hsv2rgb_pkg::SEC_YEL_GRN;
      base       = hsv2rgb_pkg::hue_t'(hsv2rgb_pkg::SECTOR_SPAN);
    end else if (hue_c < hsv2rgb_pkg::hue_t'(3 * hsv2rgb_pkg::SECTOR_SPAN)) begin
      s1_sec_nxt = hsv2rgb_pkg::SEC_GRN_CYN;
      base       = hsv2rgb_pkg::hue_t'(2 * hsv2rgb_pkg::SECTOR_SPAN);
    end else if (hue_c < hsv2rgb_pkg::hue_t'(4 * hsv2rgb_pkg::SECTOR_SPAN)) begin
      s1_sec_nxt = hsv2rgb_pkg::SEC_CYN_BLU;
      base       = hsv2rgb_pkg::hue_t'(3 * hsv2rgb_pkg::SECTOR_SPAN);
    end else if (hue_c < hsv2rgb_pkg::hue_t'(5 * hsv2rgb_pkg::SECTOR_SPAN)) begin
      s1_sec_nxt = hsv2rgb_pkg::SEC_BLU_MAG;
      base       = hsv2rgb_pkg::hue_t'(4 * hsv2rgb_pkg::SECTOR_SPAN);
    end else begin
      s1_sec_nxt = hsv2rgb_pkg::SEC_MAG_RED;
      base       = hsv2rgb_pkg::hue_t'(5 * hsv2rgb_pkg::SECTOR_SPAN);
    end

    diff = hue_c - base;
    frac = diff[hsv2rgb_pkg::FRAC_W-1:0];
    // secondary ramps up in even sectors, down in odd ones
    s1_f_nxt  = s1_sec_nxt[0] ? (hsv2rgb_pkg::FRAC_FULL - frac) : frac;
    s1_vs_nxt = hsv2rgb_pkg::vs_t'(val_c) * hsv2rgb_pkg::vs_t'(sat_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (rdy1) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_sec_r <= s1_sec_nxt;
      s1_f_r   <= s1_f_nxt;
      s1_val_r <= val_c;
      s1_vs_r  <= s1_vs_nxt;
    end
  end

  // ---------------- stage 2 ----------------
  always_comb begin
    // val*100 - val*sat never goes negative
    offs      = hsv2rgb_pkg::vs_t'(s1_val_r) * hsv2rgb_pkg::PCT_FULL - s1_vs_r;
    s2_cm_nxt = hsv2rgb_pkg::num_t'(s1_val_r) * hsv2rgb_pkg::CM_SCALE;
    s2_m_nxt  = hsv2rgb_pkg::num_t'(offs) * hsv2rgb_pkg::OFF_SCALE;
    s2_xs_nxt = hsv2rgb_pkg::num_t'(s1_vs_r) * hsv2rgb_pkg::num_t'(s1_f_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (rdy2) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_vld_r) begin
      s2_sec_r <= s1_sec_r;
      s2_cm_r  <= s2_cm_nxt;
      s2_m_r   <= s2_m_nxt;
      s2_xs_r  <= s2_xs_nxt;
    end
  end

  // ---------------- stage 3 ----------------
  always_comb begin
    xm = s2_m_r + s2_xs_r;
    unique case (s2_sec_r)
      hsv2rgb_pkg::SEC_RED_YEL: s3_num_nxt = '{red: s2_cm_r, green: xm,      blue: s2_m_r};
      hsv2rgb_pkg::SEC_YEL_GRN: s3_num_nxt = '{red: xm,      green: s2_cm_r, blue: s2_m_r};
      hsv2rgb_pkg::SEC_GRN_CYN: s3_num_nxt = '{red: s2_m_r,  green: s2_cm_r, blue: xm};
      hsv2rgb_pkg::SEC_CYN_BLU: s3_num_nxt = '{red: s2_m_r,  green: xm,      blue: s2_cm_r};
      hsv2rgb_pkg::SEC_BLU_MAG: s3_num_nxt = '{red: xm,      green: s2_m_r,  blue: s2_cm_r};
      default:                  s3_num_nxt = '{red: s2_cm_r, green: s2_m_r,  blue: xm};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (rdy3) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_vld_r) begin
      s3_num_r <= s3_num_nxt;
    end
  end

  assign num_valid = s3_vld_r;
  assign num       = s3_num_r;

endmodule

`default_nettype wire

>>> sv/hsv2rgb_scale.sv
// back end: scale numerators by 255/600000 with rounding (2 stages, last is the output register)
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_scale (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     num_valid,
  output logic                    num_ready,
  input  wire hsv2rgb_pkg::chan_num_t num,
  output logic                    rgb_valid,
  input  wire                     rgb_ready,
  output hsv2rgb_pkg::chan_t      red,
  output hsv2rgb_pkg::chan_t      green,
  output hsv2rgb_pkg::chan_t      blue
);

  // (255*n + 300000) / 64, the low bits never matter to the floor
  function automatic hsv2rgb_pkg::tq_t pre_scale(input hsv2rgb_pkg::num_t n);
    hsv2rgb_pkg::scl_t w;
    hsv2rgb_pkg::scl_t t;
    w = hsv2rgb_pkg::scl_t'(n);
    t = (w << 8) - w + hsv2rgb_pkg::HALF_NUM;
    return t[hsv2rgb_pkg::SCL_W-1:hsv2rgb_pkg::DEN_SHIFT];
  endfunction

  // floor(t / 9375) by reciprocal multiply
  function automatic hsv2rgb_pkg::chan_t quot(input hsv2rgb_pkg::tq_t t);
    hsv2rgb_pkg::prod_t p;
    p = hsv2rgb_pkg::prod_t'(t) * hsv2rgb_pkg::prod_t'(hsv2rgb_pkg::RECIP);
    return p[hsv2rgb_pkg::RECIP_SHIFT+hsv2rgb_pkg::CH_W-1:hsv2rgb_pkg::RECIP_SHIFT];
  endfunction

  logic               s4_vld_r;
  hsv2rgb_pkg::tq_t   s4_red_r, s4_green_r, s4_blue_r;
  hsv2rgb_pkg::tq_t   s4_red_nxt, s4_green_nxt, s4_blue_nxt;

  logic               s5_vld_r;
  hsv2rgb_pkg::chan_t s5_red_r, s5_green_r, s5_blue_r;
  hsv2rgb_pkg::chan_t s5_red_nxt, s5_green_nxt, s5_blue_nxt;

  logic rdy4, rdy5;

  assign rdy5      = !s5_vld_r || rgb_ready;
  assign rdy4      = !s4_vld_r || rdy5;
  assign num_ready = rdy4;

  // ---------------- stage 4 ----------------
  always_comb begin
    s4_red_nxt   = pre_scale(num.red);
    s4_green_nxt = pre_scale(num.green);
    s4_blue_nxt  = pre_scale(num.blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (rdy4) begin
      s4_vld_r <= num_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && num_valid) begin
      s4_red_r   <= s4_red_nxt;
      s4_green_r <= s4_green_nxt;
      s4_blue_r  <= s4_blue_nxt;
    end
  end

  // ---------------- stage 5 ----------------
  always_comb begin
    s5_red_nxt   = quot(s4_red_r);
    s5_green_nxt = quot(s4_green_r);
    s5_blue_nxt  = quot(s4_blue_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (rdy5) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && s4_vld_r) begin
      s5_red_r   <= s5_red_nxt;
      s5_green_r <= s5_green_nxt;
      s5_blue_r  <= s5_blue_nxt;
    end
  end

  assign rgb_valid = s5_vld_r;
  assign red       = s5_red_r;
  assign green     = s5_green_r;
  assign blue      = s5_blue_r;

endmodule

`default_nettype wire

>>> sv/hsv_to_rgb_converter.sv
// top level of the hsv to rgb converter: front end and scaler pipelines
//
// usage:
//   input channel in_valid / in_ready carries one hue (degrees), saturation
//   and value (percent) per transfer; out-of-range fields clamp to 359 / 100
//   output channel out_valid / out_ready carries the 8-bit red, green, blue
//   results, one per input transfer, in order
// path: an input transfer passes through five registered stages before out_valid
//   rises, and the result can transfer while the output is not stalled
//   (clamp/sector, terms, channel select, pre-scale, divide)
// throughput: one transfer per cycle unless stalled; every stage has its own
//   valid bit, loads whenever it is empty or its successor moves; bubbles collapse
// stall: when out_ready is low the items back up stage by stage; in_ready
//   drops only once all five stages hold an item, nothing is lost or repeated
// reset: synchronous active-low rst_n clears all stage valid bits; the
//   pipeline is empty and in_ready is high in the first cycle after reset
// the block has no state between items and no configuration
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire hsv2rgb_pkg::hue_t in_hue_deg,
  input  wire hsv2rgb_pkg::pct_t in_sat_pct,
  input  wire hsv2rgb_pkg::pct_t in_val_pct,
  output logic                   out_valid,
  input  wire                    out_ready,
  output hsv2rgb_pkg::chan_t     out_red_out,
  output hsv2rgb_pkg::chan_t     out_green_out,
  output hsv2rgb_pkg::chan_t     out_blue_out
);

  // numerators over 600000 between front end and scaler
  logic                   num_valid;
  logic                   num_ready;
  hsv2rgb_pkg::chan_num_t num;

  // clamp, sector split, chroma / secondary / offset, channel placement
  hsv2rgb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hue       (in_hue_deg),
    .sat       (in_sat_pct),
    .val       (in_val_pct),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num)
  );

  // round(255 * n / 600000), half up; its last stage is the output register
  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num),
    .rgb_valid (out_valid),
    .rgb_ready (out_ready),
    .red       (out_red_out),
    .green     (out_green_out),
    .blue      (out_blue_out)
  );

  // reset empties every stage
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !num_valid))
    else $error("pipeline not empty after reset");

  // input back-pressure only when the whole pipeline is full and stalled
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |-> (out_valid && !out_ready && num_valid))
    else $error("input stalled while pipeline has room");

  // with the output draining, an accepted item shows up at the output after passing every stage
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      |-> ##2 out_valid)
    else $error("result missing after pipeline latency");

endmodule

`default_nettype wire
